### design/ba_pkg.sv
// Shared types and constants of the buddy allocator.
// Depends on nothing; every other design file but ba_ram refers to it by scoped names.
`default_nettype none
package ba_pkg;
    localparam int MAX_MEM_LOG2_DEF   = 16;
    localparam int MIN_BLOCK_LOG2_DEF = 5;
    localparam int HEADER_BYTES_DEF   = 16;

    localparam int LOG_W     = 6;
    localparam int LEVEL_W   = 4;
    localparam int LEN_W     = 16;
    localparam int ADDR_W    = 16;
    localparam int GSZ_W     = 5;
    localparam int CFG_W     = 5;
    localparam int MEMCFG_W  = 5;
    localparam int BLKCFG_W  = 4;
    localparam int MEM_RESET = 16;
    localparam int BLK_RESET = 7;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_TOO_LARGE  = 2'd1,
        STAT_NO_BLOCK   = 2'd2,
        STAT_MERGE_STOP = 2'd3
    } t_status;

    typedef enum logic {
        CFG_MEM_LOG2 = 1'b0,
        CFG_BLK_LOG2 = 1'b1
    } t_cfg_index;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_A_SCAN, S_A_SPLIT0, S_A_SPLIT1, S_A_FINAL,
        S_F_LCHK, S_F_AREAD, S_F_ACHK, S_F_MARK,
        S_M_READ, S_M_CHK, S_M_W1, S_M_W2
    } t_state;

    typedef struct packed {
        logic [LOG_W-1:0] mem_log2;
        logic [LOG_W-1:0] blk_log2;
        logic             clear;
    } t_cfg;
endpackage
`default_nettype wire

### design/buddy_allocator.sv
// Top level of the buddy allocator: configuration registers, the node map and
// level store RAMs, and the sequencer. Depends on ba_pkg, ba_ram and ba_ctrl.
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------------------
//   request  | start / busy       | i_kind, i_request_length, i_free_address
//   result   | o_done (1 cycle)   | o_address, o_granted_size_log2, o_status
//   config   | i_cfg_we           | i_cfg_index, i_cfg_data
//
// An allocate word scans nodes (levels from the fitting size up to the root,
// lowest address first) and then splits one level at a time down to the fit.
// A free word checks the block's node and each ancestor, then merges buddies.
// The node map has a registered read port.
// After reset and after every write of mem_size_log2 a clearing pass over all
// 2^(MAX_MEM_LOG2-MIN_BLOCK_LOG2+1) node map entries holds busy high.
// Results cannot be stalled; the next word may start while o_done shows.
`default_nettype none
module buddy_allocator #(
    parameter int MAX_MEM_LOG2   = ba_pkg::MAX_MEM_LOG2_DEF,
    parameter int MIN_BLOCK_LOG2 = ba_pkg::MIN_BLOCK_LOG2_DEF,
    parameter int HEADER_BYTES   = ba_pkg::HEADER_BYTES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        i_kind,
    input  wire logic [ba_pkg::LEN_W-1:0]    i_request_length,
    input  wire logic [ba_pkg::ADDR_W-1:0]   i_free_address,
    output logic                             o_done,
    output logic [ba_pkg::ADDR_W-1:0]        o_address,
    output logic [ba_pkg::GSZ_W-1:0]         o_granted_size_log2,
    output logic [1:0]                       o_status,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_index,
    input  wire logic [ba_pkg::CFG_W-1:0]    i_cfg_data
);
    localparam int NW  = MAX_MEM_LOG2 - MIN_BLOCK_LOG2 + 1;
    localparam int LFW = MAX_MEM_LOG2 - MIN_BLOCK_LOG2;
    localparam int LW  = ba_pkg::LOG_W;

    logic [ba_pkg::MEMCFG_W-1:0] r_mem_log2;
    logic [ba_pkg::BLKCFG_W-1:0] r_blk_log2;
    logic [LW-1:0]               mraw, braw, meff, beff;
    ba_pkg::t_cfg                cfg;
    ba_pkg::t_status             stat;

    logic                        map_we, map_wdata, map_q;
    logic [NW-1:0]               map_waddr, map_raddr;
    logic                        lvl_we;
    logic [LFW-1:0]              lvl_waddr, lvl_raddr;
    logic [ba_pkg::LEVEL_W-1:0]  lvl_wdata, lvl_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_log2 <= ba_pkg::MEMCFG_W'(ba_pkg::MEM_RESET);
            r_blk_log2 <= ba_pkg::BLKCFG_W'(ba_pkg::BLK_RESET);
        end else if (i_cfg_we) begin
            if (i_cfg_index == ba_pkg::CFG_MEM_LOG2) begin
                r_mem_log2 <= i_cfg_data;
            end else begin
                r_blk_log2 <= i_cfg_data[ba_pkg::BLKCFG_W-1:0];
            end
        end
    end

    always_comb begin
        mraw = LW'(r_mem_log2);
        braw = LW'(r_blk_log2);
        if (mraw < LW'(MIN_BLOCK_LOG2 + 1)) begin
            meff = LW'(MIN_BLOCK_LOG2 + 1);
        end else if (mraw > LW'(MAX_MEM_LOG2)) begin
            meff = LW'(MAX_MEM_LOG2);
        end else begin
            meff = mraw;
        end
        if (braw < LW'(MIN_BLOCK_LOG2)) begin
            beff = LW'(MIN_BLOCK_LOG2);
        end else if (braw > meff - LW'(1)) begin
            beff = meff - LW'(1);
        end else begin
            beff = braw;
        end
        cfg.mem_log2 = meff;
        cfg.blk_log2 = beff;
        cfg.clear    = i_cfg_we && (i_cfg_index == ba_pkg::CFG_MEM_LOG2);
    end

    ba_ram #(.W(1), .D(1 << NW)) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_q     (map_q)
    );

    ba_ram #(.W(ba_pkg::LEVEL_W), .D(1 << LFW)) u_lvl (
        .i_clk   (i_clk),
        .i_we    (lvl_we),
        .i_waddr (lvl_waddr),
        .i_wdata (lvl_wdata),
        .i_raddr (lvl_raddr),
        .o_q     (lvl_q)
    );

    ba_ctrl #(
        .MAX_MEM_LOG2   (MAX_MEM_LOG2),
        .MIN_BLOCK_LOG2 (MIN_BLOCK_LOG2),
        .HEADER_BYTES   (HEADER_BYTES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_start     (start),
        .i_kind      (i_kind),
        .i_len       (i_request_length),
        .i_faddr     (i_free_address),
        .o_busy      (busy),
        .o_done      (o_done),
        .o_address   (o_address),
        .o_gsz       (o_granted_size_log2),
        .o_status    (stat),
        .o_map_we    (map_we),
        .o_map_waddr (map_waddr),
        .o_map_wdata (map_wdata),
        .o_map_raddr (map_raddr),
        .i_map_q     (map_q),
        .o_lvl_we    (lvl_we),
        .o_lvl_waddr (lvl_waddr),
        .o_lvl_wdata (lvl_wdata),
        .o_lvl_raddr (lvl_raddr),
        .i_lvl_q     (lvl_q)
    );

    assign o_status = stat;
endmodule
`default_nettype wire

### design/ba_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`default_nettype none
module ba_ram #(
    parameter int W = 1,
    parameter int D = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_q
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_q = r_q;
endmodule
`default_nettype wire

### design/ba_ctrl.sv
// Sequencer of the buddy allocator: scan, split, free check and merge passes
// over the node map and level store RAMs. Depends on ba_pkg.
`default_nettype none
module ba_ctrl #(
    parameter int MAX_MEM_LOG2   = ba_pkg::MAX_MEM_LOG2_DEF,
    parameter int MIN_BLOCK_LOG2 = ba_pkg::MIN_BLOCK_LOG2_DEF,
    parameter int HEADER_BYTES   = ba_pkg::HEADER_BYTES_DEF,
    localparam int NW  = MAX_MEM_LOG2 - MIN_BLOCK_LOG2 + 1,
    localparam int LFW = MAX_MEM_LOG2 - MIN_BLOCK_LOG2
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire ba_pkg::t_cfg                 i_cfg,
    input  wire logic                         i_start,
    input  wire logic                         i_kind,
    input  wire logic [ba_pkg::LEN_W-1:0]     i_len,
    input  wire logic [ba_pkg::ADDR_W-1:0]    i_faddr,
    output logic                              o_busy,
    output logic                              o_done,
    output logic [ba_pkg::ADDR_W-1:0]         o_address,
    output logic [ba_pkg::GSZ_W-1:0]          o_gsz,
    output ba_pkg::t_status                   o_status,
    output logic                              o_map_we,
    output logic [NW-1:0]                     o_map_waddr,
    output logic                              o_map_wdata,
    output logic [NW-1:0]                     o_map_raddr,
    input  wire logic                         i_map_q,
    output logic                              o_lvl_we,
    output logic [LFW-1:0]                    o_lvl_waddr,
    output logic [ba_pkg::LEVEL_W-1:0]        o_lvl_wdata,
    output logic [LFW-1:0]                    o_lvl_raddr,
    input  wire logic [ba_pkg::LEVEL_W-1:0]   i_lvl_q
);
    localparam int AW = ((MAX_MEM_LOG2 > ba_pkg::ADDR_W) ? MAX_MEM_LOG2 : ba_pkg::ADDR_W) + 1;
    localparam int SW = NW + 1;
    localparam int LW = ba_pkg::LOG_W;
    localparam int NEED_W = ba_pkg::LEN_W + 2;

    function automatic logic [LW-1:0] ceil_log2(input logic [NEED_W-1:0] v);
        logic [LW-1:0] r;
        r = LW'(NEED_W - 1);
        for (int i = NEED_W - 1; i >= 0; i--) begin
            if ((NEED_W'(1) << i) >= v) begin
                r = LW'(i);
            end
        end
        return r;
    endfunction

    ba_pkg::t_state  r_state, n_state;
    logic [NW-1:0]   r_cnt, n_cnt;
    logic [NW-1:0]   r_node, n_node;
    logic [NW-1:0]   r_anc, n_anc;
    logic [LW-1:0]   r_lv, n_lv;
    logic [LW-1:0]   r_t, n_t;
    logic [LW-1:0]   r_k, n_k;
    logic [AW-1:0]   r_off, n_off;
    logic [SW-1:0]   r_si, n_si;
    logic [LW-1:0]   r_slv, n_slv;
    logic            r_pv, n_pv;
    logic [NW-1:0]   r_pn, n_pn;
    logic [LW-1:0]   r_plv, n_plv;
    logic            r_sdone, n_sdone;
    logic            r_done, n_done;
    logic [ba_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic [ba_pkg::GSZ_W-1:0]  r_gsz, n_gsz;
    ba_pkg::t_status r_stat, n_stat;

    logic [NEED_W-1:0] need;
    logic [LW-1:0]     kc, ka, ta, lq, sh;
    logic [AW-1:0]     faddr_ext, foff, amask, aoff;
    logic [SW-1:0]     si_next, lvl_end;

    always_comb begin
        need      = NEED_W'(i_len) + NEED_W'(HEADER_BYTES);
        kc        = ceil_log2(need);
        ka        = (kc < i_cfg.blk_log2) ? i_cfg.blk_log2 : kc;
        ta        = i_cfg.mem_log2 - ka;
        faddr_ext = AW'(i_faddr);
        foff      = faddr_ext - AW'(HEADER_BYTES);
        lq        = LW'(i_lvl_q);
        sh        = i_cfg.mem_log2 - lq;
        amask     = (AW'(1) << sh) - AW'(1);
        aoff      = AW'(r_node - (NW'(1) << r_t)) << r_k;
        si_next   = r_si + SW'(1);
        lvl_end   = SW'(1) << (r_slv + LW'(1));

        n_state = r_state;  n_cnt = r_cnt;    n_node = r_node;  n_anc = r_anc;
        n_lv    = r_lv;     n_t   = r_t;      n_k    = r_k;     n_off = r_off;
        n_si    = r_si;     n_slv = r_slv;    n_pv   = r_pv;    n_pn  = r_pn;
        n_plv   = r_plv;    n_sdone = r_sdone;
        n_done  = 1'b0;     n_addr = r_addr;  n_gsz  = r_gsz;   n_stat = r_stat;

        o_map_we    = 1'b0;
        o_map_waddr = r_node;
        o_map_wdata = 1'b0;
        o_map_raddr = r_si[NW-1:0];
        o_lvl_we    = 1'b0;
        o_lvl_waddr = LFW'(aoff >> MIN_BLOCK_LOG2);
        o_lvl_wdata = ba_pkg::LEVEL_W'(r_t);
        o_lvl_raddr = LFW'(foff >> MIN_BLOCK_LOG2);

        unique case (r_state)
            ba_pkg::S_CLEAR: begin
                o_map_we    = 1'b1;
                o_map_waddr = r_cnt;
                o_map_wdata = (r_cnt == NW'(1));
                n_cnt       = r_cnt + NW'(1);
                if (&r_cnt) begin
                    n_state = ba_pkg::S_IDLE;
                end
            end
            ba_pkg::S_IDLE: begin
                if (i_start) begin
                    if (!i_kind) begin
                        if (ka > i_cfg.mem_log2) begin
                            n_done = 1'b1;
                            n_addr = '0;
                            n_gsz  = '0;
                            n_stat = ba_pkg::STAT_TOO_LARGE;
                        end else begin
                            n_k     = ka;
                            n_t     = ta;
                            n_si    = SW'(1) << ta;
                            n_slv   = ta;
                            n_pv    = 1'b0;
                            n_sdone = 1'b0;
                            n_state = ba_pkg::S_A_SCAN;
                        end
                    end else begin
                        if (faddr_ext < AW'(HEADER_BYTES) ||
                            foff >= (AW'(1) << i_cfg.mem_log2)) begin
                            n_done = 1'b1;
                            n_addr = '0;
                            n_gsz  = '0;
                            n_stat = ba_pkg::STAT_MERGE_STOP;
                        end else begin
                            n_off   = foff;
                            n_state = ba_pkg::S_F_LCHK;
                        end
                    end
                end
            end
            ba_pkg::S_A_SCAN: begin
                if (r_pv && i_map_q) begin
                    n_node  = r_pn;
                    n_lv    = r_plv;
                    n_state = (r_plv == r_t) ? ba_pkg::S_A_FINAL : ba_pkg::S_A_SPLIT0;
                end else if (r_sdone) begin
                    n_done  = 1'b1;
                    n_addr  = '0;
                    n_gsz   = '0;
                    n_stat  = ba_pkg::STAT_NO_BLOCK;
                    n_state = ba_pkg::S_IDLE;
                end else begin
                    n_pv  = 1'b1;
                    n_pn  = r_si[NW-1:0];
                    n_plv = r_slv;
                    if (si_next == lvl_end) begin
                        if (r_slv == '0) begin
                            n_sdone = 1'b1;
                        end else begin
                            n_slv = r_slv - LW'(1);
                            n_si  = SW'(1) << (r_slv - LW'(1));
                        end
                    end else begin
                        n_si = si_next;
                    end
                end
            end
            ba_pkg::S_A_SPLIT0: begin
                o_map_we = 1'b1;
                n_state  = ba_pkg::S_A_SPLIT1;
            end
            ba_pkg::S_A_SPLIT1: begin
                o_map_we    = 1'b1;
                o_map_waddr = {r_node[NW-2:0], 1'b1};
                o_map_wdata = 1'b1;
                n_node      = {r_node[NW-2:0], 1'b0};
                n_lv        = r_lv + LW'(1);
                n_state     = (r_lv + LW'(1) == r_t) ? ba_pkg::S_A_FINAL : ba_pkg::S_A_SPLIT0;
            end
            ba_pkg::S_A_FINAL: begin
                o_map_we = 1'b1;
                o_lvl_we = 1'b1;
                n_done   = 1'b1;
                n_addr   = ba_pkg::ADDR_W'(aoff + AW'(HEADER_BYTES));
                n_gsz    = ba_pkg::GSZ_W'(r_k);
                n_stat   = ba_pkg::STAT_OK;
                n_state  = ba_pkg::S_IDLE;
            end
            ba_pkg::S_F_LCHK: begin
                if (lq > i_cfg.mem_log2 - LW'(MIN_BLOCK_LOG2) || (|(r_off & amask))) begin
                    n_done  = 1'b1;
                    n_addr  = '0;
                    n_gsz   = '0;
                    n_stat  = ba_pkg::STAT_MERGE_STOP;
                    n_state = ba_pkg::S_IDLE;
                end else begin
                    n_node  = (NW'(1) << lq) + NW'(r_off >> sh);
                    n_anc   = (NW'(1) << lq) + NW'(r_off >> sh);
                    n_lv    = lq;
                    n_state = ba_pkg::S_F_AREAD;
                end
            end
            ba_pkg::S_F_AREAD: begin
                o_map_raddr = r_anc;
                n_state     = ba_pkg::S_F_ACHK;
            end
            ba_pkg::S_F_ACHK: begin
                if (i_map_q) begin
                    n_done  = 1'b1;
                    n_addr  = '0;
                    n_gsz   = '0;
                    n_stat  = ba_pkg::STAT_MERGE_STOP;
                    n_state = ba_pkg::S_IDLE;
                end else if (r_anc == NW'(1)) begin
                    n_state = ba_pkg::S_F_MARK;
                end else begin
                    n_anc   = r_anc >> 1;
                    n_state = ba_pkg::S_F_AREAD;
                end
            end
            ba_pkg::S_F_MARK: begin
                o_map_we    = 1'b1;
                o_map_wdata = 1'b1;
                if (r_lv == '0) begin
                    n_done  = 1'b1;
                    n_addr  = '0;
                    n_gsz   = '0;
                    n_stat  = ba_pkg::STAT_OK;
                    n_state = ba_pkg::S_IDLE;
                end else begin
                    n_state = ba_pkg::S_M_READ;
                end
            end
            ba_pkg::S_M_READ: begin
                o_map_raddr = r_node ^ NW'(1);
                n_state     = ba_pkg::S_M_CHK;
            end
            ba_pkg::S_M_CHK: begin
                if (!i_map_q) begin
                    n_done  = 1'b1;
                    n_addr  = '0;
                    n_gsz   = '0;
                    n_stat  = ba_pkg::STAT_MERGE_STOP;
                    n_state = ba_pkg::S_IDLE;
                end else begin
                    o_map_we = 1'b1;
                    n_state  = ba_pkg::S_M_W1;
                end
            end
            ba_pkg::S_M_W1: begin
                o_map_we    = 1'b1;
                o_map_waddr = r_node ^ NW'(1);
                n_state     = ba_pkg::S_M_W2;
            end
            ba_pkg::S_M_W2: begin
                o_map_we    = 1'b1;
                o_map_waddr = r_node >> 1;
                o_map_wdata = 1'b1;
                n_node      = r_node >> 1;
                n_lv        = r_lv - LW'(1);
                if (r_lv == LW'(1)) begin
                    n_done  = 1'b1;
                    n_addr  = '0;
                    n_gsz   = '0;
                    n_stat  = ba_pkg::STAT_OK;
                    n_state = ba_pkg::S_IDLE;
                end else begin
                    n_state = ba_pkg::S_M_READ;
                end
            end
            default: begin
                n_state = ba_pkg::S_CLEAR;
                n_cnt   = '0;
            end
        endcase

        if (i_cfg.clear) begin
            n_state = ba_pkg::S_CLEAR;
            n_cnt   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ba_pkg::S_CLEAR;
            r_cnt   <= '0;
            r_pv    <= 1'b0;
            r_sdone <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pv    <= n_pv;
            r_sdone <= n_sdone;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node <= n_node;
        r_anc  <= n_anc;
        r_lv   <= n_lv;
        r_t    <= n_t;
        r_k    <= n_k;
        r_off  <= n_off;
        r_si   <= n_si;
        r_slv  <= n_slv;
        r_pn   <= n_pn;
        r_plv  <= n_plv;
        r_addr <= n_addr;
        r_gsz  <= n_gsz;
        r_stat <= n_stat;
    end

    assign o_busy    = (r_state != ba_pkg::S_IDLE);
    assign o_done    = r_done;
    assign o_address = r_addr;
    assign o_gsz     = r_gsz;
    assign o_status  = r_stat;
endmodule
`default_nettype wire

### design/ba_checker.sv
// Port-level assertions for the buddy allocator, bound to its top level.
// Depends on ba_pkg and buddy_allocator.
`default_nettype none
module ba_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_done,
    input wire logic [15:0] o_address,
    input wire logic [4:0]  o_granted_size_log2,
    input wire logic [1:0]  o_status
);
    a_accept_works: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted word neither busy nor answered");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ba_pkg::STAT_OK) |->
        (o_address == 16'd0 && o_granted_size_log2 == 5'd0))
        else $error("error result carries nonzero fields");

    a_done_caused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) || $past(start)))
        else $error("result without a word in progress");

    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> busy)
        else $error("not clearing after reset");
endmodule

bind buddy_allocator ba_checker u_ba_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .start               (start),
    .busy                (busy),
    .o_done              (o_done),
    .o_address           (o_address),
    .o_granted_size_log2 (o_granted_size_log2),
    .o_status            (o_status)
);
`default_nettype wire

### verif/buddy_allocator_tb.sv
// Self-checking testbench for buddy_allocator: a directed table, then random
// allocate and free words over several region and block settings, checked
// against a behavioral predictor of the split tree. Depends on ba_pkg and buddy_allocator.
`timescale 1ns / 100ps
module buddy_allocator_tb;
    import ba_pkg::*;

    localparam int HDR        = HEADER_BYTES_DEF;
    localparam int MINB       = MIN_BLOCK_LOG2_DEF;
    localparam int MAXM       = MAX_MEM_LOG2_DEF;
    localparam int NODES      = 1 << (MAXM - MINB + 1);
    localparam int LEAVES     = 1 << (MAXM - MINB);
    localparam int IDLE_LIMIT = 60000;
    localparam bit KIND_ALLOC = 1'b0;
    localparam bit KIND_FREE  = 1'b1;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [GSZ_W-1:0]  gsz;
        t_status           st;
    } t_grant;

    typedef struct {
        bit                kind;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] fa;
        bit                typed;
        t_grant            res;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_kind;
    logic [LEN_W-1:0]  i_request_length;
    logic [ADDR_W-1:0] i_free_address;
    logic              o_done;
    logic [ADDR_W-1:0] o_address;
    logic [GSZ_W-1:0]  o_granted_size_log2;
    logic [1:0]        o_status;
    logic              i_cfg_we;
    logic              i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;

    bit                free_map [NODES];
    logic [3:0]        level_of [LEAVES];
    int                mem_reg;
    int                blk_reg;
    logic [ADDR_W-1:0] live_q[$];
    logic [ADDR_W-1:0] granted_q[$];
    t_grant            grant_q[$];
    t_row              rows[$];
    int                errors;
    int                words_sent;
    int                words_done;
    int                cfg_writes;
    int                idle_cycles;
    int                burst_left;

    buddy_allocator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_kind(i_kind), .i_request_length(i_request_length),
        .i_free_address(i_free_address), .o_done(o_done), .o_address(o_address),
        .o_granted_size_log2(o_granted_size_log2), .o_status(o_status),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_tree();
        for (int i = 0; i < NODES; i++) free_map[i] = 1'b0;
        free_map[1] = 1'b1;
        live_q.delete();
    endfunction

    function automatic t_grant buddy_predict(bit kind, int len, int fa);
        t_grant r;
        int m, b, k, t, lv, hit, n, a, off, need;
        bit found;
        r.addr = '0;
        r.gsz = '0;
        m = (mem_reg < MINB + 1) ? MINB + 1 : (mem_reg > MAXM) ? MAXM : mem_reg;
        b = (blk_reg < MINB) ? MINB : (blk_reg > m - 1) ? m - 1 : blk_reg;
        if (kind == KIND_ALLOC) begin
            need = len + HDR;
            k = 0;
            while ((1 << k) < need) k++;
            if (k < b) k = b;
            if (k > m) begin
                r.st = STAT_TOO_LARGE;
                return r;
            end
            t = m - k;
            found = 1'b0;
            hit = 0;
            n = 0;
            for (lv = t; lv >= 0 && !found; lv--) begin
                for (int i = 1 << lv; i < (2 << lv) && !found; i++) begin
                    if (free_map[i]) begin
                        n = i;
                        hit = lv;
                        found = 1'b1;
                    end
                end
            end
            if (!found) begin
                r.st = STAT_NO_BLOCK;
                return r;
            end
            while (hit < t) begin
                free_map[n] = 1'b0;
                free_map[2 * n + 1] = 1'b1;
                n = 2 * n;
                hit++;
            end
            free_map[n] = 1'b0;
            off = (n - (1 << t)) << k;
            level_of[off >> MINB] = t[3:0];
            r.addr = ADDR_W'(off + HDR);
            r.gsz = k[GSZ_W-1:0];
            r.st = STAT_OK;
            live_q.push_back(r.addr);
            granted_q.push_back(r.addr);
            return r;
        end
        r.st = STAT_MERGE_STOP;
        for (int i = 0; i < live_q.size(); i++) begin
            if (live_q[i] == fa) begin
                live_q.delete(i);
                break;
            end
        end
        if (fa < HDR) return r;
        off = fa - HDR;
        if (off >= (1 << m)) return r;
        lv = level_of[off >> MINB];
        if (lv > m - MINB) return r;
        if ((off & ((1 << (m - lv)) - 1)) != 0) return r;
        n = (1 << lv) + (off >> (m - lv));
        for (a = n; a >= 1; a = a >> 1) begin
            if (free_map[a]) return r;
        end
        free_map[n] = 1'b1;
        while (lv > 0) begin
            if (!free_map[n ^ 1]) return r;
            free_map[n] = 1'b0;
            free_map[n ^ 1] = 1'b0;
            n = n >> 1;
            lv--;
            free_map[n] = 1'b1;
        end
        r.st = STAT_OK;
        return r;
    endfunction

    function automatic void add_row(bit kind, int len, int fa, bit typed,
                                    int ea, int eg, t_status es);
        t_row w;
        w.kind = kind;
        w.len = len[LEN_W-1:0];
        w.fa = fa[ADDR_W-1:0];
        w.typed = typed;
        w.res.addr = ea[ADDR_W-1:0];
        w.res.gsz = eg[GSZ_W-1:0];
        w.res.st = es;
        rows.push_back(w);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    task automatic send_word(bit kind, logic [LEN_W-1:0] len, logic [ADDR_W-1:0] fa,
                             bit typed, t_grant res);
        t_grant p;
        int gap;
        i_kind <= kind;
        i_request_length <= len;
        i_free_address <= fa;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        p = buddy_predict(kind, len, fa);
        grant_q.push_back(typed ? res : p);
        words_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 8);
            gap = $urandom_range(1, 25);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(t_cfg_index idx, int val);
        start <= 1'b0;
        while (grant_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_writes++;
        if (idx == CFG_MEM_LOG2) begin
            mem_reg = val & 5'h1f;
            clear_tree();
        end else begin
            blk_reg = val & 4'hf;
        end
    endtask

    task automatic random_word();
        int m, sel;
        t_grant none;
        logic [ADDR_W-1:0] fa;
        none.addr = '0;
        none.gsz = '0;
        none.st = STAT_OK;
        m = (mem_reg < MINB + 1) ? MINB + 1 : (mem_reg > MAXM) ? MAXM : mem_reg;
        sel = $urandom_range(0, 99);
        if (sel < 65 || granted_q.size() == 0) begin
            sel = $urandom_range(0, 99);
            if (sel < 60)
                send_word(KIND_ALLOC, LEN_W'($urandom_range(0, (1 << (m - 2)))), '0, 0,
                          none);
            else if (sel < 85)
                send_word(KIND_ALLOC, LEN_W'($urandom_range(0, 600)), '0, 0, none);
            else
                send_word(KIND_ALLOC, LEN_W'($urandom), ADDR_W'($urandom), 0, none);
            return;
        end
        sel = $urandom_range(0, 99);
        if (sel < 70 && live_q.size() != 0)
            fa = live_q[$urandom_range(0, live_q.size() - 1)];
        else if (sel < 80)
            fa = ADDR_W'($urandom_range(0, HDR - 1));
        else if (sel < 88 && m < MAXM)
            fa = ADDR_W'($urandom_range(HDR + (1 << m), 16'hffff));
        else
            fa = ADDR_W'(granted_q[$urandom_range(0, granted_q.size() - 1)]
                         + $urandom_range(0, (1 << MINB) - 1));
        send_word(KIND_FREE, LEN_W'($urandom), fa, 0, none);
    endtask

    always @(posedge i_clk) begin
        t_grant w;
        if (start && !busy || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        if (i_rst_n && o_done) begin
            words_done++;
            if (grant_q.size() == 0) begin
                $display("MISMATCH: result word with nothing expected at %0t", $time);
                errors++;
            end else begin
                w = grant_q.pop_front();
                if (o_address !== w.addr) report_mismatch("address", o_address, w.addr);
                if (o_granted_size_log2 !== w.gsz)
                    report_mismatch("granted_size_log2", o_granted_size_log2, w.gsz);
                if (o_status !== w.st) report_mismatch("status", o_status, w.st);
            end
        end
    end

    initial begin
        int mem_set[7] = '{6, 16, 16, 8, 31, 3, 10};
        int blk_set[7] = '{5, 5, 15, 15, 0, 9, 6};
        errors = 0;
        words_sent = 0;
        words_done = 0;
        cfg_writes = 0;
        idle_cycles = 0;
        burst_left = 0;
        mem_reg = MEM_RESET;
        blk_reg = BLK_RESET;
        for (int i = 0; i < LEAVES; i++) level_of[i] = '0;
        clear_tree();
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_kind <= 1'b0;
        i_request_length <= '0;
        i_free_address <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= 1'b0;
        i_cfg_data <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_row(KIND_ALLOC, 0, 0, 1, 16, 7, STAT_OK);
        add_row(KIND_ALLOC, 16'hffff, 0, 1, 0, 0, STAT_TOO_LARGE);
        add_row(KIND_ALLOC, 16'hfff0, 0, 1, 0, 0, STAT_NO_BLOCK);
        add_row(KIND_FREE, 0, 0, 1, 0, 0, STAT_MERGE_STOP);
        add_row(KIND_FREE, 16'hffff, 15, 1, 0, 0, STAT_MERGE_STOP);
        add_row(KIND_FREE, 0, 16, 1, 0, 0, STAT_OK);
        add_row(KIND_ALLOC, 16'hfff0, 0, 1, 16, 16, STAT_OK);
        add_row(KIND_ALLOC, 0, 0, 1, 0, 0, STAT_NO_BLOCK);
        add_row(KIND_FREE, 0, 16, 1, 0, 0, STAT_OK);
        add_row(KIND_FREE, 0, 16, 1, 0, 0, STAT_MERGE_STOP);
        add_row(KIND_ALLOC, 100, 0, 0, 0, 0, STAT_OK);
        add_row(KIND_ALLOC, 112, 0, 0, 0, 0, STAT_OK);
        add_row(KIND_ALLOC, 113, 0, 0, 0, 0, STAT_OK);
        add_row(KIND_ALLOC, 4000, 0, 0, 0, 0, STAT_OK);
        add_row(KIND_FREE, 0, 144, 0, 0, 0, STAT_OK);
        add_row(KIND_FREE, 0, 145, 0, 0, 0, STAT_OK);
        add_row(KIND_FREE, 0, 16, 0, 0, 0, STAT_OK);
        add_row(KIND_FREE, 0, 272, 0, 0, 0, STAT_OK);
        add_row(KIND_FREE, 0, 4112, 0, 0, 0, STAT_OK);
        add_row(KIND_FREE, 0, 4112, 0, 0, 0, STAT_OK);
        foreach (rows[i]) send_word(rows[i].kind, rows[i].len, rows[i].fa,
                                    rows[i].typed, rows[i].res);

        for (int n = 0; n < 60; n++) random_word();
        for (int p = 0; p < 7; p++) begin
            write_reg(CFG_MEM_LOG2, mem_set[p]);
            write_reg(CFG_BLK_LOG2, blk_set[p]);
            for (int n = 0; n < 55; n++) random_word();
        end

        start <= 1'b0;
        while (grant_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Covered %0d request words, %0d result words, %0d register writes.",
                 words_sent, words_done, cfg_writes);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", errors);
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

### buddy_allocator.f
design/ba_pkg.sv
design/ba_ram.sv
design/ba_ctrl.sv
design/buddy_allocator.sv
design/ba_checker.sv
verif/buddy_allocator_tb.sv
